FILE: rtl/min_heap_huffman_merge_core_macros.svh
// Assertion macros shared by the heap core RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef MIN_HEAP_HUFFMAN_MERGE_CORE_MACROS_SVH
`define MIN_HEAP_HUFFMAN_MERGE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MHHM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mhhm: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MHHM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mhhm: next-cycle check failed");

`endif

FILE: rtl/mhhm_pkg.sv
// Shared types and constants for the min-heap Huffman merge core.
// No dependencies; used by every module of the core.
package mhhm_pkg;

    localparam int HEAP_CAPACITY = 256;
    localparam int WEIGHT_BITS   = 32;
    localparam int TAG_BITS      = 9;
    localparam int OP_BITS       = 2;
    localparam int STATUS_BITS   = 2;
    localparam int CNT_BITS      = $clog2(HEAP_CAPACITY + 1);
    localparam int SLOT_BITS     = WEIGHT_BITS + TAG_BITS;

    // Operation codes
    localparam logic [OP_BITS-1:0] OP_INSERT  = OP_BITS'(0);
    localparam logic [OP_BITS-1:0] OP_EXTRACT = OP_BITS'(1);
    localparam logic [OP_BITS-1:0] OP_COMBINE = OP_BITS'(2);

    // Status codes
    localparam logic [STATUS_BITS-1:0] ST_OK    = STATUS_BITS'(0);
    localparam logic [STATUS_BITS-1:0] ST_FULL  = STATUS_BITS'(1);
    localparam logic [STATUS_BITS-1:0] ST_SHORT = STATUS_BITS'(2);

    typedef struct packed {
        logic [OP_BITS-1:0]     op;
        logic [WEIGHT_BITS-1:0] weight;
        logic [TAG_BITS-1:0]    tag;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [WEIGHT_BITS-1:0] out_weight;
        logic [TAG_BITS-1:0]    out_tag;
        logic [CNT_BITS-1:0]    entry_count;
        logic                   last;
    } out_item_t;

    // One heap entry as stored in the RAM
    typedef struct packed {
        logic [WEIGHT_BITS-1:0] weight;
        logic [TAG_BITS-1:0]    tag;
    } slot_t;

    // Result handed from the sequencer to the output queue
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } res_push_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_POP,
        S_DOWN,
        S_UP,
        S_UP_FIN,
        S_NEXT,
        S_EMIT0,
        S_EMIT1
    } seq_state_t;

endpackage

FILE: rtl/mhhm_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// Depends on mhhm_pkg for its default parameters.
module mhhm_ram #(
    parameter int WIDTH = mhhm_pkg::SLOT_BITS,
    parameter int DEPTH = mhhm_pkg::HEAP_CAPACITY
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read two
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata0 <= mem[raddr0];
            rdata1 <= mem[raddr1];
        end
    end

endmodule

FILE: rtl/mhhm_seq.sv
// Heap sequencer: runs insert, extract and combine over the heap RAM.
// Depends on mhhm_pkg, mhhm_ram and the assertion macro header.
`include "min_heap_huffman_merge_core_macros.svh"

module mhhm_seq #(
    parameter int CAPACITY = mhhm_pkg::HEAP_CAPACITY
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  mhhm_pkg::in_item_t  req,
    output mhhm_pkg::res_push_t push,
    input  logic                push_ready
);
    import mhhm_pkg::*;

    localparam int IW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    // Control and working registers
    seq_state_t      state_reg, state_next;
    in_item_t        req_reg, req_next;
    logic [IW-1:0]   cnt_reg, cnt_next;
    logic [IW-1:0]   idx_reg, idx_next;
    slot_t           mov_reg, mov_next;
    slot_t           pop_a_reg, pop_a_next;
    slot_t           pop_b_reg, pop_b_next;
    logic [1:0]      pops_reg, pops_next;
    logic            pushed_reg, pushed_next;
    logic [STATUS_BITS-1:0] status_reg, status_next;

    // RAM port signals
    logic                 mem_we;
    logic                 mem_re;
    logic [AW-1:0]        mem_waddr;
    logic [SLOT_BITS-1:0] mem_wdata;
    logic [AW-1:0]        mem_raddr0;
    logic [AW-1:0]        mem_raddr1;
    logic [SLOT_BITS-1:0] mem_rdata0;
    logic [SLOT_BITS-1:0] mem_rdata1;
    slot_t                rd0_slot;
    slot_t                rd1_slot;

    // Decision signals
    logic [IW:0]          child_l;
    logic [IW:0]          child_r;
    logic [IW:0]          cnt_ext;
    logic                 l_less;
    logic [WEIGHT_BITS-1:0] l_pick_w;
    logic                 r_less;
    logic                 dn_move;
    logic [IW:0]          dn_pick;
    logic [IW:0]          dn_pick_l;
    logic [IW:0]          dn_pick_r;
    logic                 dn_more;
    slot_t                dn_child;
    logic [IW-1:0]        par_idx;
    logic [IW-1:0]        gpar_idx;
    logic                 up_less;
    logic                 up_top;
    logic [IW-1:0]        cnt_inc;
    logic [IW-1:0]        cnt_dec;
    logic [IW-1:0]        new_par;
    logic                 cnt_full;
    logic                 cnt_zero;
    logic                 cnt_short;
    logic [WEIGHT_BITS:0] sum_full;
    logic [WEIGHT_BITS-1:0] sum_sat;
    slot_t                push_slot;
    logic                 emit_last;

    // Map a heap index (from 1) to a RAM address
    function automatic logic [AW-1:0] addr_of(input logic [IW:0] idx);
        logic [IW:0] off;
        off = idx - 1'b1;
        return off[AW-1:0];
    endfunction

    mhhm_ram #(
        .WIDTH (SLOT_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (mem_waddr),
        .wdata  (mem_wdata),
        .re     (mem_re),
        .raddr0 (mem_raddr0),
        .raddr1 (mem_raddr1),
        .rdata0 (mem_rdata0),
        .rdata1 (mem_rdata1)
    );

    assign rd0_slot = slot_t'(mem_rdata0);
    assign rd1_slot = slot_t'(mem_rdata1);

    // Sift-down: pick the strictly lighter child, left first
    assign child_l   = {idx_reg, 1'b0};
    assign child_r   = {idx_reg, 1'b1};
    assign cnt_ext   = {1'b0, cnt_reg};
    assign l_less    = (child_l <= cnt_ext) && (rd0_slot.weight < mov_reg.weight);
    assign l_pick_w  = l_less ? rd0_slot.weight : mov_reg.weight;
    assign r_less    = (child_r <= cnt_ext) && (rd1_slot.weight < l_pick_w);
    assign dn_move   = l_less || r_less;
    assign dn_pick   = r_less ? child_r : child_l;
    assign dn_pick_l = {dn_pick[IW-1:0], 1'b0};
    assign dn_pick_r = {dn_pick[IW-1:0], 1'b1};
    assign dn_more   = dn_pick_l <= cnt_ext;
    assign dn_child  = r_less ? rd1_slot : rd0_slot;

    // Sift-up: swap while strictly lighter than the parent
    assign par_idx   = idx_reg >> 1;
    assign gpar_idx  = par_idx >> 1;
    assign up_less   = mov_reg.weight < rd0_slot.weight;
    assign up_top    = par_idx == IW'(1);

    // Occupancy
    assign cnt_inc   = cnt_reg + 1'b1;
    assign cnt_dec   = cnt_reg - 1'b1;
    assign new_par   = cnt_inc >> 1;
    assign cnt_full  = cnt_reg == IW'(CAPACITY);
    assign cnt_zero  = cnt_reg == '0;
    assign cnt_short = cnt_reg < IW'(2);

    // Saturating sum of the two popped weights
    assign sum_full  = {1'b0, pop_a_reg.weight} + {1'b0, pop_b_reg.weight};
    assign sum_sat   = sum_full[WEIGHT_BITS] ? '1 : sum_full[WEIGHT_BITS-1:0];

    assign push_slot.weight = (req_reg.op == OP_COMBINE) ? sum_sat : req_reg.weight;
    assign push_slot.tag    = req_reg.tag;

    assign emit_last = !((req_reg.op == OP_COMBINE) && (status_reg == ST_OK));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (req_reg.op)
                    OP_INSERT:
                    begin
                        priority if (cnt_full)
                            state_next = S_EMIT0;
                        else if (cnt_zero)
                            state_next = S_NEXT;
                        else
                            state_next = S_UP;
                    end
                    OP_EXTRACT: state_next = cnt_zero ? S_EMIT0 : S_POP;
                    OP_COMBINE: state_next = cnt_short ? S_EMIT0 : S_POP;
                    default:    state_next = S_IDLE;
                endcase
            end
            S_POP:
            begin
                state_next = (cnt_reg == IW'(1)) ? S_NEXT : S_DOWN;
            end
            S_DOWN:
            begin
                if (!dn_move)
                begin
                    state_next = S_NEXT;
                end
            end
            S_UP:
            begin
                priority if (!up_less)
                    state_next = S_NEXT;
                else if (up_top)
                    state_next = S_UP_FIN;
                else
                    state_next = S_UP;
            end
            S_UP_FIN:
            begin
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                unique case (req_reg.op)
                    OP_INSERT:  state_next = S_EMIT0;
                    OP_EXTRACT: state_next = S_EMIT0;
                    OP_COMBINE:
                    begin
                        priority if (pushed_reg)
                            state_next = S_EMIT0;
                        else if (pops_reg == 2'd1)
                            state_next = S_POP;
                        else if (cnt_zero)
                            state_next = S_NEXT;
                        else
                            state_next = S_UP;
                    end
                    default:    state_next = S_IDLE;
                endcase
            end
            S_EMIT0:
            begin
                if (push_ready)
                begin
                    state_next = emit_last ? S_IDLE : S_EMIT1;
                end
            end
            S_EMIT1:
            begin
                if (push_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath, RAM control and outputs. Reads are always issued after
    // the write they depend on, so no forwarding path is needed.
    always_comb
    begin
        req_next    = req_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        mov_next    = mov_reg;
        pop_a_next  = pop_a_reg;
        pop_b_next  = pop_b_reg;
        pops_next   = pops_reg;
        pushed_next = pushed_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = mov_reg;
        mem_re      = 1'b0;
        mem_raddr0  = '0;
        mem_raddr1  = '0;
        req_ready   = 1'b0;
        push        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                // Take a new item
                req_ready = 1'b1;
                if (req_valid)
                begin
                    req_next    = req;
                    pops_next   = 2'd0;
                    pushed_next = 1'b0;
                    status_next = ST_OK;
                end
            end
            S_DISPATCH:
            begin
                unique case (req_reg.op)
                    OP_INSERT:
                    begin
                        if (cnt_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            // Place at the new tail and look at its parent
                            cnt_next = cnt_inc;
                            idx_next = cnt_inc;
                            mov_next = push_slot;
                            if (cnt_zero)
                            begin
                                mem_we      = 1'b1;
                                mem_waddr   = addr_of((IW+1)'(1));
                                mem_wdata   = push_slot;
                                pushed_next = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr0 = addr_of({1'b0, new_par});
                                mem_raddr1 = addr_of({1'b0, new_par});
                            end
                        end
                    end
                    OP_EXTRACT, OP_COMBINE:
                    begin
                        if ((req_reg.op == OP_EXTRACT) ? cnt_zero : cnt_short)
                        begin
                            status_next = ST_SHORT;
                        end
                        else
                        begin
                            // Fetch root and tail
                            mem_re     = 1'b1;
                            mem_raddr0 = addr_of((IW+1)'(1));
                            mem_raddr1 = addr_of({1'b0, cnt_reg});
                        end
                    end
                    default:
                    begin
                        status_next = status_reg;
                    end
                endcase
            end
            S_POP:
            begin
                // Save the root, move the tail to the root, fetch its children
                if (pops_reg == 2'd0)
                    pop_a_next = rd0_slot;
                else
                    pop_b_next = rd0_slot;
                pops_next = pops_reg + 2'd1;
                mov_next  = rd1_slot;
                cnt_next  = cnt_dec;
                idx_next  = IW'(1);
                if (cnt_reg != IW'(1))
                begin
                    mem_re     = 1'b1;
                    mem_raddr0 = addr_of((IW+1)'(2));
                    mem_raddr1 = addr_of((IW+1)'(3));
                end
            end
            S_DOWN:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_of({1'b0, idx_reg});
                if (dn_move)
                begin
                    // Lift the lighter child, descend
                    mem_wdata = dn_child;
                    idx_next  = dn_pick[IW-1:0];
                    if (dn_more)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr0 = addr_of(dn_pick_l);
                        mem_raddr1 = addr_of(dn_pick_r);
                    end
                end
                else
                begin
                    mem_wdata = mov_reg;
                end
            end
            S_UP:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_of({1'b0, idx_reg});
                if (up_less)
                begin
                    // Pull the parent down, climb
                    mem_wdata = rd0_slot;
                    idx_next  = par_idx;
                    if (!up_top)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr0 = addr_of({1'b0, gpar_idx});
                        mem_raddr1 = addr_of({1'b0, gpar_idx});
                    end
                end
                else
                begin
                    mem_wdata   = mov_reg;
                    pushed_next = 1'b1;
                end
            end
            S_UP_FIN:
            begin
                mem_we      = 1'b1;
                mem_waddr   = addr_of({1'b0, idx_reg});
                mem_wdata   = mov_reg;
                pushed_next = 1'b1;
            end
            S_NEXT:
            begin
                if ((req_reg.op == OP_COMBINE) && !pushed_reg)
                begin
                    if (pops_reg == 2'd1)
                    begin
                        // Second pop: fetch root and tail
                        mem_re     = 1'b1;
                        mem_raddr0 = addr_of((IW+1)'(1));
                        mem_raddr1 = addr_of({1'b0, cnt_reg});
                    end
                    else
                    begin
                        // Push the merged node
                        cnt_next = cnt_inc;
                        idx_next = cnt_inc;
                        mov_next = push_slot;
                        if (cnt_zero)
                        begin
                            mem_we      = 1'b1;
                            mem_waddr   = addr_of((IW+1)'(1));
                            mem_wdata   = push_slot;
                            pushed_next = 1'b1;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr0 = addr_of({1'b0, new_par});
                            mem_raddr1 = addr_of({1'b0, new_par});
                        end
                    end
                end
            end
            S_EMIT0:
            begin
                push.valid            = 1'b1;
                push.item.status      = status_reg;
                push.item.entry_count = CNT_BITS'(cnt_reg);
                push.item.last        = emit_last;
                priority if (req_reg.op == OP_INSERT)
                begin
                    push.item.out_weight = req_reg.weight;
                    push.item.out_tag    = req_reg.tag;
                end
                else if (status_reg != ST_OK)
                begin
                    push.item.out_weight = '0;
                    push.item.out_tag    = '0;
                end
                else
                begin
                    push.item.out_weight = pop_a_reg.weight;
                    push.item.out_tag    = pop_a_reg.tag;
                end
            end
            S_EMIT1:
            begin
                push.valid            = 1'b1;
                push.item.status      = ST_OK;
                push.item.out_weight  = pop_b_reg.weight;
                push.item.out_tag     = pop_b_reg.tag;
                push.item.entry_count = CNT_BITS'(cnt_reg);
                push.item.last        = 1'b1;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            pops_reg   <= 2'd0;
            pushed_reg <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            pops_reg   <= pops_next;
            pushed_reg <= pushed_next;
            status_reg <= status_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        idx_reg   <= idx_next;
        mov_reg   <= mov_next;
        pop_a_reg <= pop_a_next;
        pop_b_reg <= pop_b_next;
    end

    `MHHM_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= IW'(CAPACITY))
    `MHHM_ASSERT_IMPL(a_cnt_step, clk, rst_n, 1'b1, (cnt_reg == $past(cnt_reg)) || (cnt_reg == $past(cnt_reg) + 1'b1) || (cnt_reg == $past(cnt_reg) - 1'b1))
    `MHHM_ASSERT_IMPL(a_no_mem_overlap, clk, rst_n, mem_we && mem_re, (mem_waddr != mem_raddr0) && (mem_waddr != mem_raddr1))

endmodule

FILE: rtl/min_heap_huffman_merge_core.sv
// One item is worked at a time; a successful combine queues its two results in order. The
// next item is taken once the sequencer is back in S_IDLE, after the last result of the
// current one is queued. The sift walks set the rate, one heap level per cycle through the
// heap RAM. A two-entry output queue parts the sides.
// Reset clears the occupancy and control state; heap RAM is not cleared.
`include "min_heap_huffman_merge_core_macros.svh"

module min_heap_huffman_merge_core #(
    parameter int CAPACITY = mhhm_pkg::HEAP_CAPACITY
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  mhhm_pkg::in_item_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output mhhm_pkg::out_item_t rsp
);
    import mhhm_pkg::*;

    localparam int FIFO_DEPTH = 2;
    localparam int PW         = $clog2(FIFO_DEPTH);

    res_push_t          push;
    logic               push_ready;
    logic               fifo_wr;
    logic               fifo_rd;
    out_item_t          fifo_mem_reg [FIFO_DEPTH];
    logic [PW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [PW:0]        fifo_cnt_reg, fifo_cnt_next;

    mhhm_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .push       (push),
        .push_ready (push_ready)
    );

    // Output queue handshake
    assign push_ready = fifo_cnt_reg != (PW+1)'(FIFO_DEPTH);
    assign fifo_wr    = push.valid && push_ready;
    assign rsp_valid  = fifo_cnt_reg != '0;
    assign fifo_rd    = rsp_valid && rsp_ready;
    assign rsp        = fifo_mem_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next   = fifo_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next   = fifo_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fifo_cnt_next = fifo_cnt_reg + (PW+1)'(fifo_wr) - (PW+1)'(fifo_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            fifo_cnt_reg <= fifo_cnt_next;
        end
    end

    // Hold queued items
    always_ff @(posedge clk)
    begin
        if (fifo_wr)
        begin
            fifo_mem_reg[wr_ptr_reg] <= push.item;
        end
    end

    `MHHM_ASSERT_IMPL(a_partial_ok, clk, rst_n, rsp_valid && !rsp.last, rsp.status == ST_OK)
    `MHHM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_valid && req_ready, !req_ready)
    `MHHM_ASSERT_IMPL(a_count_bound, clk, rst_n, rsp_valid, rsp.entry_count <= CAPACITY)

endmodule

FILE: test/testbench.sv
// Self-checking testbench for min_heap_huffman_merge_core: insert, extract-minimum and
// Huffman combine items checked against a behavioral heap kept in the testbench.
// Depends on mhhm_pkg and the core RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mhhm_pkg::*;

    localparam logic [OP_BITS-1:0] OP_IGNORED = OP_BITS'(3);
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int RANDOM_ITEMS   = 900;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = '1;
    localparam logic [TAG_BITS-1:0]    TAG_MAX    = '1;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    in_item_t  req = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    out_item_t rsp;

    // Stimulus waiting to be driven and results waiting to be seen
    in_item_t  req_backlog[$];
    out_item_t heap_results_q[$];

    // Behavioral heap, indexed from 1
    slot_t       heap_mem [1:HEAP_CAPACITY];
    int unsigned heap_size = 0;

    // Occupancy as seen while stimulus is being generated
    int unsigned gen_occupancy = 0;
    int          random_issued = 0;

    // Handshake flags from the last rising edge
    logic req_taken = 1'b0;
    int   req_gap = 0;
    bit   req_quiet = 1'b0;
    int   rsp_stall = 0;
    bit   rsp_quiet = 1'b0;

    int fail_count = 0;
    int stall_cycles = 0;
    int n_insert = 0, n_extract = 0, n_combine = 0, n_ignored = 0;
    int n_checked = 0, n_full = 0, n_short = 0, n_saturated = 0;
    int unsigned peak_size = 0;

    min_heap_huffman_merge_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #10 clk = ~clk;

    // Heap behavior

    function automatic void heap_swap(int unsigned a, int unsigned b);
        slot_t tmp;
        tmp = heap_mem[a];
        heap_mem[a] = heap_mem[b];
        heap_mem[b] = tmp;
    endfunction

    function automatic void heap_push(logic [WEIGHT_BITS-1:0] w, logic [TAG_BITS-1:0] t);
        int unsigned i;
        heap_size++;
        heap_mem[heap_size].weight = w;
        heap_mem[heap_size].tag    = t;
        i = heap_size;
        // Sift up only while strictly lighter than the parent
        while (i > 1 && heap_mem[i].weight < heap_mem[i / 2].weight)
        begin
            heap_swap(i, i / 2);
            i = i / 2;
        end
    endfunction

    function automatic slot_t heap_pop();
        slot_t       top;
        int unsigned i, l, r, pick;
        bit          moving;
        top = heap_mem[1];
        heap_mem[1] = heap_mem[heap_size];
        heap_size--;
        i = 1;
        moving = 1'b1;
        // Sift down: left child first, right child only if strictly lighter still
        while (moving)
        begin
            l = 2 * i;
            r = l + 1;
            pick = i;
            if (l <= heap_size && heap_mem[l].weight < heap_mem[pick].weight)
                pick = l;
            if (r <= heap_size && heap_mem[r].weight < heap_mem[pick].weight)
                pick = r;
            if (pick == i)
                moving = 1'b0;
            else
            begin
                heap_swap(i, pick);
                i = pick;
            end
        end
        return top;
    endfunction

    function automatic void heap_result(logic [STATUS_BITS-1:0] st, logic [WEIGHT_BITS-1:0] w,
                                        logic [TAG_BITS-1:0] t, logic fin);
        out_item_t r;
        r.status      = st;
        r.out_weight  = w;
        r.out_tag     = t;
        r.entry_count = CNT_BITS'(heap_size);
        r.last        = fin;
        heap_results_q = {heap_results_q, r};
    endfunction

    // Apply one accepted item to the heap and queue the results it causes
    function automatic void heap_apply(in_item_t it);
        slot_t        a, b;
        logic [WEIGHT_BITS:0] sum;
        case (it.op)
            OP_INSERT:
            begin
                if (heap_size >= HEAP_CAPACITY)
                begin
                    n_full++;
                    heap_result(ST_FULL, it.weight, it.tag, 1'b1);
                end
                else
                begin
                    heap_push(it.weight, it.tag);
                    heap_result(ST_OK, it.weight, it.tag, 1'b1);
                end
            end
            OP_EXTRACT:
            begin
                if (heap_size < 1)
                begin
                    n_short++;
                    heap_result(ST_SHORT, '0, '0, 1'b1);
                end
                else
                begin
                    a = heap_pop();
                    heap_result(ST_OK, a.weight, a.tag, 1'b1);
                end
            end
            OP_COMBINE:
            begin
                if (heap_size < 2)
                begin
                    n_short++;
                    heap_result(ST_SHORT, '0, '0, 1'b1);
                end
                else
                begin
                    a = heap_pop();
                    b = heap_pop();
                    sum = a.weight + b.weight;
                    // Saturate the merged weight
                    if (sum > WEIGHT_MAX)
                    begin
                        sum = WEIGHT_MAX;
                        n_saturated++;
                    end
                    heap_push(sum[WEIGHT_BITS-1:0], it.tag);
                    heap_result(ST_OK, a.weight, a.tag, 1'b0);
                    heap_result(ST_OK, b.weight, b.tag, 1'b1);
                end
            end
            default: ;  // drop: no result, no state change
        endcase
        if (heap_size > peak_size)
            peak_size = heap_size;
    endfunction

    // Stimulus helpers

    function automatic void queue_req(logic [OP_BITS-1:0] op, logic [WEIGHT_BITS-1:0] w,
                                      logic [TAG_BITS-1:0] t);
        in_item_t it;
        it.op = op;
        it.weight = w;
        it.tag = t;
        req_backlog = {req_backlog, it};
        // Track occupancy so the phases can steer toward full and empty
        if (op == OP_INSERT && gen_occupancy < HEAP_CAPACITY)
            gen_occupancy++;
        else if ((op == OP_EXTRACT && gen_occupancy >= 1) ||
                 (op == OP_COMBINE && gen_occupancy >= 2))
            gen_occupancy--;
        if (op != OP_IGNORED)
            random_issued++;
    endfunction

    function automatic logic [WEIGHT_BITS-1:0] rand_weight();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom;
        else if (r < 70)
            return $urandom_range(0, 15);         // many ties
        else if (r < 85)
            return WEIGHT_MAX - $urandom_range(0, 255);  // push sums into saturation
        else
            return $urandom_range(0, 65535);
    endfunction

    // Pick an op from percentages of insert, extract and combine; the rest are ignored ops
    function automatic logic [OP_BITS-1:0] rand_op(int p_ins, int p_ext, int p_comb);
        int r;
        r = $urandom_range(0, 99);
        if (r < p_ins)
            return OP_INSERT;
        else if (r < p_ins + p_ext)
            return OP_EXTRACT;
        else if (r < p_ins + p_ext + p_comb)
            return OP_COMBINE;
        else
            return OP_IGNORED;
    endfunction

    function automatic void queue_random(int p_ins, int p_ext, int p_comb);
        queue_req(rand_op(p_ins, p_ext, p_comb), rand_weight(),
                  TAG_BITS'($urandom_range(0, TAG_MAX)));
    endfunction

    function automatic int idle_len(bit quiet);
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 80);
    endfunction

    // Request driver: hold until accepted, then idle or present the next item
    always @(negedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!req_valid || req_taken)
        begin
            if (req_valid)
            begin
                if ($urandom_range(0, 49) == 0)
                    req_quiet = !req_quiet;
                req_gap = idle_len(req_quiet);
            end
            if (req_gap > 0)
            begin
                req_valid <= 1'b0;
                req_gap--;
            end
            else if (req_backlog.size() > 0)
            begin
                req <= req_backlog.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Response back-pressure: random stalls with quiet stretches
    always @(negedge clk)
    begin
        int n;
        if (!rst_n)
            rsp_ready <= 1'b0;
        else if (rsp_stall > 0)
        begin
            rsp_ready <= 1'b0;
            rsp_stall--;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                rsp_quiet = !rsp_quiet;
            n = (rsp_quiet || $urandom_range(0, 1)) ? 0 : idle_len(1'b0);
            if (n > 0)
            begin
                rsp_ready <= 1'b0;
                rsp_stall = n - 1;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    function automatic void check_field(string name, longint unsigned exp_v,
                                        longint unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // Monitor: predict on accepted items, check accepted results, run the watchdog
    always @(posedge clk)
    begin
        out_item_t exp_r;
        if (rst_n)
        begin
            req_taken <= req_valid && req_ready;
            if (req_valid && req_ready)
            begin
                case (req.op)
                    OP_INSERT:  n_insert++;
                    OP_EXTRACT: n_extract++;
                    OP_COMBINE: n_combine++;
                    default:    n_ignored++;
                endcase
                heap_apply(req);
            end
            if (rsp_valid && rsp_ready)
            begin
                if (heap_results_q.size() == 0)
                begin
                    $error("result with nothing expected: status %0d weight 0x%0h tag %0d",
                           rsp.status, rsp.out_weight, rsp.out_tag);
                    fail_count++;
                end
                else
                begin
                    exp_r = heap_results_q.pop_front();
                    check_field("status", exp_r.status, rsp.status);
                    check_field("out_weight", exp_r.out_weight, rsp.out_weight);
                    check_field("out_tag", exp_r.out_tag, rsp.out_tag);
                    check_field("entry_count", exp_r.entry_count, rsp.entry_count);
                    check_field("last", exp_r.last, rsp.last);
                    n_checked++;
                end
            end
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                         stall_cycles, heap_results_q.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        // Empty heap: both pops report too few entries
        queue_req(OP_EXTRACT, WEIGHT_MAX, TAG_MAX);
        queue_req(OP_COMBINE, '0, '0);
        queue_req(OP_INSERT, '0, '0);
        // One entry is too few to combine
        queue_req(OP_COMBINE, 32'h1234_5678, 9'h0AA);
        queue_req(OP_IGNORED, 32'hDEAD_BEEF, 9'h155);
        queue_req(OP_INSERT, WEIGHT_MAX, TAG_MAX);
        queue_req(OP_INSERT, WEIGHT_MAX, 9'h155);
        queue_req(OP_COMBINE, '0, 9'h0AA);
        // Two maximum weights: the sum saturates
        queue_req(OP_COMBINE, WEIGHT_MAX, TAG_MAX);
        queue_req(OP_EXTRACT, '0, '0);
        queue_req(OP_EXTRACT, '0, '0);
        // Equal weights exercise the strict less-than ordering
        queue_req(OP_INSERT, 32'd5, 9'd1);
        queue_req(OP_INSERT, 32'd5, 9'd2);
        queue_req(OP_INSERT, 32'd5, 9'd3);
        queue_req(OP_INSERT, 32'd3, 9'd4);
        queue_req(OP_INSERT, 32'h5555_5555, 9'h0AA);
        queue_req(OP_INSERT, 32'hAAAA_AAAA, 9'h155);
        queue_req(OP_EXTRACT, '0, '0);
        queue_req(OP_COMBINE, '0, TAG_MAX);
        queue_req(OP_EXTRACT, '0, '0);
        queue_req(OP_COMBINE, '0, '0);
        queue_req(OP_EXTRACT, '0, '0);
        queue_req(OP_EXTRACT, '0, '0);
        random_issued = 0;

        // Mixed traffic at moderate occupancy
        while (random_issued < 200)
            queue_random(50, 22, 23);
        // Fill to capacity, then keep inserting into the full heap
        while (gen_occupancy < HEAP_CAPACITY)
            queue_random(85, 5, 7);
        repeat (14)
            queue_random(90, 0, 0);
        // Drain to empty, then pop past empty
        while (gen_occupancy > 0)
            queue_random(3, 45, 50);
        repeat (6)
            queue_random(0, 45, 50);
        // Mixed traffic to the end
        while (random_issued < RANDOM_ITEMS)
            queue_random(45, 25, 27);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (req_backlog.size() > 0 || req_valid)
            @(posedge clk);
        while (heap_results_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Accepted %0d inserts, %0d extracts, %0d combines, %0d ignored ops;",
                 n_insert, n_extract, n_combine, n_ignored);
        $display("checked %0d results: %0d full, %0d short, %0d saturated sums, peak size %0d.",
                 n_checked, n_full, n_short, n_saturated, peak_size);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
